// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Beat types, field codes and sequencer states shared by the interpolator
// core and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

	// Fixed field widths.
	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int REGION_W = 2;

	// Number of breakpoints in use after reset.
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd2;

	// Quotient bits produced by the divider, one per cycle.
	localparam int DIV_STEPS = 32;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Result regions.
	localparam logic [REGION_W-1:0] REGION_FIRST    = 2'd0;
	localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd1;
	localparam logic [REGION_W-1:0] REGION_LAST     = 2'd2;

	// One input beat.
	typedef struct packed {
		logic                       kind;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
	} pli_item_t;

	// One result beat.
	typedef struct packed {
		logic signed [COORD_W-1:0]  result_y;
		logic [INDEX_W-1:0]         segment_index;
		logic [REGION_W-1:0]        region;
		logic                       bad_segment;
	} pli_result_t;

	// Query sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SEG_LO,
		ST_SEG_HI,
		ST_SEG_CHK,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} pli_state_t;

endpackage

`default_nettype wire

// ===== src/piecewise_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator core
// Breakpoint table in one synchronous memory, binary search for the segment,
// one 32x32 multiply and a bit-serial divider for the interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready/item) takes load and query beats.
//   A load beat writes one breakpoint (x, y) in its accept cycle and gives no
//   result; an entry_index beyond the table is dropped. A query beat gives one
//   beat on the result channel (result_valid/result_ready/result).
//   cfg_write_en/cfg_write_data set the number of breakpoints in use.
// Sequencing:
//   Loads may follow each other back to back while the sequencer is idle.
//   A query occupies the sequencer until its result is in the output register;
//   it reads the first point and then the last point to check the clamps,
//   runs S binary search probes for a query between them, where S is about
//   log2(point_count) + 1, then reads and checks the segment. Each probe
//   costs a memory read and a compare; an interior segment not flagged bad
//   then costs a multiply and a bit-serial division, one quotient bit per
//   cycle.
// Reset and stalls:
//   Reset clears the sequencer and the output valid flag and sets the point
//   count to 2; table contents are undefined until loaded. A stalled receiver
//   holds the result in the output register while the next item is accepted;
//   a finished query then waits in its last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_core #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write_en,
	input  wire logic [pli_pkg::COUNT_W-1:0]      cfg_write_data,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire pli_pkg::pli_item_t               item,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output pli_pkg::pli_result_t                  result
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int NW  = $clog2(TABLE_DEPTH + 1);
	localparam int DCW = $clog2(pli_pkg::DIV_STEPS);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(pli_pkg::DIV_STEPS - 1);

	// Control registers.
	pli_pkg::pli_state_t            state_q, state_d;
	logic [pli_pkg::COUNT_W-1:0]    count_q;
	logic                           out_valid_q;
	pli_pkg::pli_result_t           out_q;

	// Datapath registers.
	logic [63:0]                    point_mem_q [TABLE_DEPTH];
	logic [63:0]                    rd_data_q;
	logic signed [31:0]             q_q;
	logic [NW-1:0]                  n_q;
	logic [NW-1:0]                  lo_q;
	logic [NW-1:0]                  len_q;
	logic [AW-1:0]                  seg_q;
	logic signed [31:0]             x0_q;
	logic signed [31:0]             y0_q;
	logic [31:0]                    dx_q;
	logic [31:0]                    dq_q;
	logic [31:0]                    mag_q;
	logic                           neg_q;
	logic [31:0]                    rem_q;
	logic [31:0]                    shf_q;
	logic [DCW-1:0]                 cnt_q;
	pli_pkg::pli_result_t           res_q;

	// Combinational signals.
	logic                           item_fire;
	logic                           load_we;
	logic [AW-1:0]                  rd_addr;
	logic                           out_free;
	logic                           out_load;
	logic [NW-1:0]                  n_clamped;
	logic [AW-1:0]                  last_idx;
	logic [NW-1:0]                  half;
	logic [NW-1:0]                  mid;
	logic [NW-1:0]                  lo_m1;
	logic [NW-1:0]                  n_m2;
	logic [NW-1:0]                  j_full;
	logic signed [31:0]             rd_x;
	logic signed [31:0]             rd_y;
	logic                           seg_bad;
	logic [32:0]                    dy33;
	logic [32:0]                    dx33;
	logic [32:0]                    mag33;
	logic [63:0]                    prod;
	logic [32:0]                    trial;
	logic [32:0]                    trial_diff;
	logic                           trial_fits;
	logic [31:0]                    res_calc;

	assign item_fire = item_valid && item_ready;
	assign load_we   = item_fire && (item.kind == pli_pkg::KIND_LOAD) &&
	                   (32'(item.entry_index) < 32'(TABLE_DEPTH));

	// Breakpoint table: x in the upper half, y in the lower half.
	always_ff @(posedge clk) begin
		if (load_we) begin
			point_mem_q[AW'(item.entry_index)] <= {item.point_x, item.point_y};
		end
		rd_data_q <= point_mem_q[rd_addr];
	end

	assign rd_x = rd_data_q[63:32];
	assign rd_y = rd_data_q[31:0];

	// Effective point count, held to the range 1 to TABLE_DEPTH.
	always_comb begin
		if (count_q == '0) begin
			n_clamped = NW'(1);
		end else if (32'(count_q) > 32'(TABLE_DEPTH)) begin
			n_clamped = NW'(TABLE_DEPTH);
		end else begin
			n_clamped = NW'(count_q);
		end
	end

	assign last_idx = AW'(n_q - NW'(1));

	// Binary search probe and final segment index.
	assign half   = len_q >> 1;
	assign mid    = lo_q + half;
	assign lo_m1  = (lo_q == '0) ? '0 : lo_q - NW'(1);
	assign n_m2   = n_q - NW'(2);
	assign j_full = (lo_m1 > n_m2) ? n_m2 : lo_m1;

	// Segment check and operand preparation; rd_data_q holds the upper point.
	assign seg_bad = (rd_x <= x0_q) || (q_q < x0_q) || (q_q >= rd_x);
	assign dy33    = {rd_y[31], rd_y} - {y0_q[31], y0_q};
	assign dx33    = {rd_x[31], rd_x} - {x0_q[31], x0_q};
	assign mag33   = dy33[32] ? (~dy33 + 33'd1) : dy33;

	// Product of the slope magnitude and the query offset.
	assign prod = 64'(mag_q) * 64'(dq_q);

	// One restoring division step per cycle.
	assign trial      = {rem_q, shf_q[31]};
	assign trial_diff = trial - {1'b0, dx_q};
	assign trial_fits = (trial >= {1'b0, dx_q});

	// Apply the quotient with the sign of the slope; wraps to 32 bits.
	assign res_calc = neg_q ? (32'(y0_q) - shf_q) : (32'(y0_q) + shf_q);

	assign out_free = !out_valid_q || result_ready;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				if (item_fire && (item.kind == pli_pkg::KIND_QUERY)) begin
					state_d = pli_pkg::ST_RD_FIRST;
				end
			end
			pli_pkg::ST_RD_FIRST: begin
				state_d = pli_pkg::ST_RD_LAST;
			end
			pli_pkg::ST_RD_LAST: begin
				state_d = (q_q <= rd_x) ? pli_pkg::ST_DONE : pli_pkg::ST_CHK_LAST;
			end
			pli_pkg::ST_CHK_LAST: begin
				state_d = (q_q >= rd_x) ? pli_pkg::ST_DONE : pli_pkg::ST_SRCH_RD;
			end
			pli_pkg::ST_SRCH_RD: begin
				state_d = (len_q == '0) ? pli_pkg::ST_SEG_LO : pli_pkg::ST_SRCH_CMP;
			end
			pli_pkg::ST_SRCH_CMP: begin
				state_d = pli_pkg::ST_SRCH_RD;
			end
			pli_pkg::ST_SEG_LO: begin
				state_d = pli_pkg::ST_SEG_HI;
			end
			pli_pkg::ST_SEG_HI: begin
				state_d = pli_pkg::ST_SEG_CHK;
			end
			pli_pkg::ST_SEG_CHK: begin
				state_d = seg_bad ? pli_pkg::ST_DONE : pli_pkg::ST_MUL;
			end
			pli_pkg::ST_MUL: begin
				state_d = pli_pkg::ST_DIV;
			end
			pli_pkg::ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = pli_pkg::ST_FIN;
				end
			end
			pli_pkg::ST_FIN: begin
				state_d = pli_pkg::ST_DONE;
			end
			pli_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pli_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: table read address, input ready, result hand-off.
	always_comb begin
		rd_addr    = '0;
		item_ready = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			pli_pkg::ST_IDLE:     item_ready = 1'b1;
			pli_pkg::ST_RD_FIRST: rd_addr = '0;
			pli_pkg::ST_RD_LAST:  rd_addr = last_idx;
			pli_pkg::ST_SRCH_RD:  rd_addr = AW'(mid);
			pli_pkg::ST_SEG_LO:   rd_addr = seg_q;
			pli_pkg::ST_SEG_HI:   rd_addr = seg_q + AW'(1);
			pli_pkg::ST_DONE:     out_load = out_free;
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pli_pkg::ST_IDLE;
			count_q     <= pli_pkg::COUNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				count_q <= cfg_write_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				if (item_fire) begin
					q_q <= item.point_x;
					n_q <= n_clamped;
				end
			end
			pli_pkg::ST_RD_LAST: begin
				res_q <= '{result_y: rd_y, segment_index: '0,
				           region: pli_pkg::REGION_FIRST, bad_segment: 1'b0};
			end
			pli_pkg::ST_CHK_LAST: begin
				res_q <= '{result_y: rd_y, segment_index: 8'(last_idx),
				           region: pli_pkg::REGION_LAST, bad_segment: 1'b0};
				lo_q  <= '0;
				len_q <= n_q;
			end
			pli_pkg::ST_SRCH_RD: begin
				seg_q <= AW'(j_full);
			end
			pli_pkg::ST_SRCH_CMP: begin
				if (rd_x <= q_q) begin
					lo_q  <= mid + NW'(1);
					len_q <= len_q - half - NW'(1);
				end else begin
					len_q <= half;
				end
			end
			pli_pkg::ST_SEG_HI: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			pli_pkg::ST_SEG_CHK: begin
				res_q <= '{result_y: y0_q, segment_index: 8'(seg_q),
				           region: pli_pkg::REGION_INTERIOR, bad_segment: 1'b1};
				dx_q  <= dx33[31:0];
				dq_q  <= 32'(q_q) - 32'(x0_q);
				mag_q <= mag33[31:0];
				neg_q <= dy33[32];
			end
			pli_pkg::ST_MUL: begin
				rem_q <= prod[63:32];
				shf_q <= prod[31:0];
				cnt_q <= '0;
			end
			pli_pkg::ST_DIV: begin
				rem_q <= trial_fits ? trial_diff[31:0] : trial[31:0];
				shf_q <= {shf_q[30:0], trial_fits};
				cnt_q <= cnt_q + DCW'(1);
			end
			pli_pkg::ST_FIN: begin
				res_q <= '{result_y: res_calc, segment_index: 8'(seg_q),
				           region: pli_pkg::REGION_INTERIOR, bad_segment: 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== src/pli_checker.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator port checker
// Watches the core's ports for handshake and result-format violations.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        item_valid,
	input wire logic                        item_ready,
	input wire pli_pkg::pli_item_t          item,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire pli_pkg::pli_result_t        result
);

	// A stalled result beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
	else $error("result beat changed while stalled");

	// A load beat never produces a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.kind == pli_pkg::KIND_LOAD) && !result_valid
		|=> !result_valid)
	else $error("result appeared after a load beat");

	// The core is busy right after taking a query.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.kind == pli_pkg::KIND_QUERY) |=> !item_ready)
	else $error("item accepted while a query is in progress");

	// Only interior segments can be flagged bad.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_segment |-> result.region == pli_pkg::REGION_INTERIOR)
	else $error("bad segment flagged outside the interior");

	// Clamping at the first point reports segment zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.region == pli_pkg::REGION_FIRST) |-> result.segment_index == '0)
	else $error("first-point clamp with nonzero segment");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

// ===== test/piecewise_linear_interpolator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator core testbench
// Loads breakpoint tables of several shapes and sizes, sends query beats
// against them and checks every result beat against a local model of the
// table search and the fixed-point interpolation. The sender works in bursts
// and the receiver stalls on its own pattern; the point count is changed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_DEPTH  = 256;
	localparam int          DRAIN_CYCLES = 80;
	localparam int unsigned BEAT_TARGET  = 1350;
	localparam longint      X_MIN        = -64'sd2147483648;
	localparam longint      X_MAX        = 64'sd2147483647;

	// Clock, reset and the ports of the core.
	logic                          clk            = 1'b0;
	logic                          arst_n         = 1'b0;
	logic                          cfg_write_en   = 1'b0;
	logic [pli_pkg::COUNT_W-1:0]   cfg_write_data = '0;
	logic                          item_valid     = 1'b0;
	logic                          item_ready;
	pli_pkg::pli_item_t            item           = '0;
	logic                          result_valid;
	logic                          result_ready   = 1'b0;
	pli_pkg::pli_result_t          result;

	// Beats waiting to be sent and results waiting to arrive.
	pli_pkg::pli_item_t            pending_items[$];
	pli_pkg::pli_result_t          predicted_results[$];
	int unsigned                   beats_queued = 0;
	int unsigned                   beats_taken  = 0;
	int unsigned                   fail_count   = 0;

	// Model of the core: breakpoints as accepted and the point count in use.
	logic signed [31:0]            break_x[TABLE_DEPTH];
	logic signed [31:0]            break_y[TABLE_DEPTH];
	logic [pli_pkg::COUNT_W-1:0]   active_count = pli_pkg::COUNT_RESET;

	// Breakpoints as queued, used to aim queries at the table being built.
	logic signed [31:0]            plan_x[TABLE_DEPTH];
	logic signed [31:0]            plan_y[TABLE_DEPTH];

	// Sender burst state and receiver stall state.
	int unsigned                   burst_left = 0;
	int unsigned                   gap_left   = 0;
	int unsigned                   ready_mode = 0;
	int unsigned                   mode_timer = 0;
	int unsigned                   stall_left = 0;
	pli_pkg::pli_result_t          oldest_result;

	piecewise_linear_interpolator_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result)
	);

	always #5 clk = ~clk;

	// Expected result of a query at q against the breakpoints loaded so far.
	function automatic pli_pkg::pli_result_t interpolate_at(input logic signed [31:0] q);
		pli_pkg::pli_result_t  r;
		int unsigned           n, lo, span, half, mid, j;
		longint                x0, x1, y0, y1, dy, res;
		longint unsigned       dx, dq, mag, quot;
		n = active_count;
		if (n < 1) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		r = '0;
		if (q <= break_x[0]) begin
			r.result_y = break_y[0];
			r.segment_index = '0;
			r.region = pli_pkg::REGION_FIRST;
		end else if (q >= break_x[n-1]) begin
			r.result_y = break_y[n-1];
			r.segment_index = 8'(n - 1);
			r.region = pli_pkg::REGION_LAST;
		end else begin
			// Upper bound search: first entry whose x exceeds the query.
			lo = 0;
			span = n;
			while (span > 0) begin
				half = span / 2;
				mid = lo + half;
				if (break_x[mid] <= q) begin
					lo = mid + 1;
					span = span - half - 1;
				end else begin
					span = half;
				end
			end
			j = (lo == 0) ? 0 : lo - 1;
			if (j > n - 2) j = n - 2;
			x0 = break_x[j];
			x1 = break_x[j+1];
			y0 = break_y[j];
			y1 = break_y[j+1];
			r.segment_index = 8'(j);
			r.region = pli_pkg::REGION_INTERIOR;
			if (x1 <= x0 || q < x0 || q >= x1) begin
				r.bad_segment = 1'b1;
				res = y0;
			end else begin
				// Exact magnitude product, quotient truncated toward zero.
				dy = y1 - y0;
				dx = x1 - x0;
				dq = q - x0;
				mag = (dy < 0) ? -dy : dy;
				quot = (mag * dq) / dx;
				res = (dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot);
			end
			r.result_y = res[31:0];
		end
		return r;
	endfunction

	// Queue one beat; loads also update the planned table.
	task automatic push_beat(input logic kind, input logic [7:0] idx,
			input logic [31:0] x, input logic [31:0] y);
		pli_pkg::pli_item_t b;
		b.kind = kind;
		b.entry_index = idx;
		b.point_x = x;
		b.point_y = y;
		pending_items.push_back(b);
		beats_queued++;
		if (kind == pli_pkg::KIND_LOAD) begin
			plan_x[idx] = x;
			plan_y[idx] = y;
		end
	endtask

	task automatic push_query(input logic [31:0] q);
		push_beat(pli_pkg::KIND_QUERY, 8'($urandom), q, $urandom);
	endtask

	// Block until every queued beat is taken and every result has arrived.
	task automatic wait_idle();
		while (beats_taken != beats_queued || predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic [pli_pkg::COUNT_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		active_count = value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Load entries 0..n-1 with a table of random shape.
	task automatic load_breakpoints(input int unsigned n);
		int unsigned shape, i, step, jitter;
		longint      slack, base, xv;
		logic [31:0] yv;
		shape = $urandom_range(0, 4);
		if (shape == 1)
			step = $urandom_range(1, 4);
		else
			step = $urandom_range(1, 32'(64'hFFFFFFFF / n));
		slack = 64'hFFFFFFFF - longint'(n) * longint'(step);
		base = X_MIN + longint'($urandom_range(0, 32'(slack)));
		for (i = 0; i < n; i++) begin
			jitter = $urandom_range(0, step - 1);
			xv = base + longint'(i) * longint'(step) + longint'(jitter);
			// Repeated x values and fully random tables.
			if (shape == 2 && i > 0 && $urandom_range(0, 3) == 0)
				xv = plan_x[i-1];
			if (shape == 3)
				xv = longint'(signed'($urandom));
			yv = $urandom_range(0, 1) ? $urandom : ($urandom >>> $urandom_range(0, 24));
			if (shape == 4 && i > 0 && $urandom_range(0, 2) == 0)
				yv = plan_y[i-1];
			push_beat(pli_pkg::KIND_LOAD, 8'(i), xv[31:0], yv);
		end
	endtask

	// Query aimed mostly inside segments, some at breakpoints and outside.
	task automatic push_random_query(input int unsigned n);
		int unsigned pick, k;
		longint      lo_x, hi_x, q;
		pick = $urandom_range(0, 9);
		lo_x = plan_x[0];
		hi_x = plan_x[n-1];
		if (pick < 6 && n >= 2) begin
			k = $urandom_range(0, n - 2);
			lo_x = plan_x[k];
			hi_x = plan_x[k+1];
			if (hi_x > lo_x)
				q = lo_x + longint'($urandom_range(0, 32'(hi_x - lo_x)));
			else
				q = lo_x;
		end else if (pick == 6) begin
			q = plan_x[$urandom_range(0, n - 1)];
		end else if (pick == 7) begin
			q = X_MIN + longint'($urandom_range(0, 32'(lo_x - X_MIN)));
		end else if (pick == 8) begin
			q = X_MAX - longint'($urandom_range(0, 32'(X_MAX - hi_x)));
		end else begin
			q = longint'(signed'($urandom));
		end
		push_query(q[31:0]);
	endtask

	task automatic flag_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
		end
	endtask

	// Driver: takes beats from the pending queue in bursts with gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				beats_taken++;
				if (item.kind == pli_pkg::KIND_QUERY) begin
					predicted_results.push_back(interpolate_at(item.point_x));
				end else if (item.entry_index < TABLE_DEPTH) begin
					break_x[item.entry_index] = item.point_x;
					break_y[item.entry_index] = item.point_y;
				end
			end
			if (!item_valid || item_ready) begin
				if (gap_left != 0 || pending_items.size() == 0) begin
					if (gap_left != 0) gap_left--;
					item_valid <= 1'b0;
				end else begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Monitor: checks each result beat and drives the receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (predicted_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with no query outstanding, %s %h",
						$time, "expected none, actual", result);
				end else begin
					oldest_result = predicted_results.pop_front();
					flag_field("result_y", oldest_result.result_y, result.result_y);
					flag_field("segment_index", 32'(oldest_result.segment_index),
						32'(result.segment_index));
					flag_field("region", 32'(oldest_result.region), 32'(result.region));
					flag_field("bad_segment", 32'(oldest_result.bad_segment),
						32'(result.bad_segment));
				end
			end
			// Stall mode changes now and then: none, short and frequent, long and rare.
			if (mode_timer == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_timer = $urandom_range(200, 1500);
			end else begin
				mode_timer--;
			end
			if (stall_left != 0) begin
				stall_left--;
			end else begin
				case (ready_mode)
					1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 4);
					2: if ($urandom_range(0, 30) == 0) stall_left = $urandom_range(8, 60);
					default: ;
				endcase
			end
			result_ready <= (stall_left == 0);
		end
	end

	// Stimulus: directed phases first, then random phases.
	initial begin
		int unsigned phase_no, pick, cnt, n, mix, i, idx;
		logic [31:0] xv;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Two points spanning the whole coordinate range, reset count of two.
		push_beat(pli_pkg::KIND_LOAD, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		push_beat(pli_pkg::KIND_LOAD, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000);
		push_beat(pli_pkg::KIND_QUERY, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF);
		push_beat(pli_pkg::KIND_QUERY, 8'hFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_beat(pli_pkg::KIND_QUERY, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
		push_beat(pli_pkg::KIND_QUERY, 8'h00, 32'h8000_0001, 32'h0000_0000);
		push_beat(pli_pkg::KIND_QUERY, 8'h00, 32'h7FFF_FFFE, 32'h0000_0000);

		// A single point in use, then a count of zero that acts as one.
		set_point_count(9'd1);
		push_query(32'h8000_0000);
		push_query(32'h0000_0005);
		set_point_count(9'd0);
		push_query(32'hFFFF_FFFF);
		push_query(32'h8000_0000);

		// Rising, flat and vertical segments.
		set_point_count(9'd4);
		push_beat(pli_pkg::KIND_LOAD, 8'd0, 32'h0000_0000, 32'hFFFC_0000);
		push_beat(pli_pkg::KIND_LOAD, 8'd1, 32'h0001_0000, 32'h0000_0100);
		push_beat(pli_pkg::KIND_LOAD, 8'd2, 32'h0002_0000, 32'h0000_0100);
		push_beat(pli_pkg::KIND_LOAD, 8'd3, 32'h0002_0000, 32'h7FFF_FFFF);
		push_query(32'h0000_8000);
		push_query(32'h0001_8000);
		push_query(32'h0002_0000);
		push_query(32'h0000_0000);

		// Random phases; the largest counts come first.
		phase_no = 0;
		while (beats_queued < BEAT_TARGET) begin
			pick = $urandom_range(0, 99);
			if (phase_no == 0)
				cnt = 511;
			else if (phase_no == 1)
				cnt = 256;
			else if (pick < 8)
				cnt = $urandom_range(0, 1);
			else if (pick < 85)
				cnt = $urandom_range(2, 16);
			else if (pick < 96)
				cnt = $urandom_range(17, 64);
			else
				cnt = $urandom_range(65, 511);
			phase_no++;
			set_point_count(pli_pkg::COUNT_W'(cnt));
			n = (cnt < 1) ? 1 : ((cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt);
			load_breakpoints(n);
			mix = $urandom_range(10, 50);
			for (i = 0; i < mix; i++) begin
				if ($urandom_range(0, 99) < 85) begin
					push_random_query(n);
				end else begin
					// Stray load: new y, sometimes a random x that breaks the order.
					idx = $urandom_range(0, TABLE_DEPTH - 1);
					xv = $urandom_range(0, 1) ? $urandom : plan_x[idx];
					push_beat(pli_pkg::KIND_LOAD, 8'(idx), xv, $urandom);
				end
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
